[sv/tcb_pkg.sv]
// ----------------------------------------------------------------------------
// tcb_pkg
// Shared types and constants for the terrain corner blend pixel core.
// ----------------------------------------------------------------------------
`default_nettype none

package tcb_pkg;

   localparam int MAX_PRECISION  = 4;
   localparam int PREC_WIDTH     = 3;
   localparam int CSR_DATA_WIDTH = 3;
   localparam int CSR_IDX_WIDTH  = 1;
   localparam int RECIP_WIDTH    = 12;
   localparam int RECIP_SHIFT    = 11;
   localparam int WEIGHT_WIDTH   = 4;

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_SAMPLE_PRECISION = 1'b0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_NOISE_ENABLE     = 1'b1;

   localparam logic [PREC_WIDTH-1:0] PRECISION_RESET = 3'd2;
   localparam logic [7:0]            ALPHA_OPAQUE    = 8'd255;

   typedef struct packed {
      logic [3:0]        pos_x;
      logic [3:0]        pos_y;
      logic [15:0]       id_top_left;
      logic [15:0]       id_top_right;
      logic [15:0]       id_bottom_right;
      logic [15:0]       id_bottom_left;
      logic [23:0]       color_top_left;
      logic [23:0]       color_top_right;
      logic [23:0]       color_bottom_right;
      logic [23:0]       color_bottom_left;
      logic signed [7:0] noise_value;
   } req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic       was_uniform;
   } rsp_type;

   // Corner order: top-left, top-right, bottom-right, bottom-left.
   typedef logic [3:0][WEIGHT_WIDTH-1:0] weight_type;
   typedef logic [3:0][7:0]              corner_chan_type;

   typedef struct packed {
      logic s2;
      logic s3;
   } stage_en_type;

   // Reciprocal of (2^p - 1) scaled by 2^RECIP_SHIFT; exact floor division
   // for every 8-bit dividend.
   function automatic logic [RECIP_WIDTH-1:0] recip_of(input logic [PREC_WIDTH-1:0] prec);
      logic [RECIP_WIDTH-1:0] r;
      begin
         unique case (prec)
            3'd1:    r = 12'd2048;
            3'd2:    r = 12'd684;
            3'd3:    r = 12'd293;
            3'd4:    r = 12'd137;
            default: r = 12'd0;
         endcase
         return r;
      end
   endfunction

endpackage

`default_nettype wire

[sv/tcb_channel.sv]
// ----------------------------------------------------------------------------
// tcb_channel
// One color channel of the blend: per-corner divide by (S-1) via a scaled
// reciprocal, then the weighted sum with saturation. Two register stages.
// ----------------------------------------------------------------------------
`default_nettype none

module tcb_channel (
   input  wire                          clock,
   input  tcb_pkg::stage_en_type        stage_en,
   input  tcb_pkg::corner_chan_type     chan,
   input  wire [tcb_pkg::RECIP_WIDTH-1:0] recip,
   input  tcb_pkg::weight_type          weight,
   output logic [7:0]                   sum
);

   localparam int PROD_WIDTH = 8 + tcb_pkg::RECIP_WIDTH;
   localparam int WSUM_WIDTH = 8 + tcb_pkg::WEIGHT_WIDTH + 2;

   tcb_pkg::corner_chan_type quot_ff, quot_in;
   logic [7:0]               sum_ff, sum_in;
   logic [WSUM_WIDTH-1:0]    wsum;
   logic [PROD_WIDTH-1:0]    prod [4];

   always_comb begin
      for (int k = 0; k < 4; k++) begin
         prod[k]    = PROD_WIDTH'(chan[k]) * PROD_WIDTH'(recip);
         quot_in[k] = 8'(prod[k] >> tcb_pkg::RECIP_SHIFT);
      end
   end

   always_comb begin
      wsum = '0;
      for (int k = 0; k < 4; k++) begin
         wsum = wsum + WSUM_WIDTH'(weight[k]) * WSUM_WIDTH'(quot_ff[k]);
      end
      sum_in = (wsum > WSUM_WIDTH'(255)) ? 8'd255 : wsum[7:0];
   end

   always_ff @(posedge clock) begin
      if (stage_en.s2) begin
         quot_ff <= quot_in;
      end
      if (stage_en.s3) begin
         sum_ff <= sum_in;
      end
   end

   assign sum = sum_ff;

endmodule

`default_nettype wire

[sv/terrain_corner_blend_pixel_core.sv]
// ----------------------------------------------------------------------------
// terrain_corner_blend_pixel_core
// Blends the four corner material colors of a terrain cell into one RGBA
// colormap pixel, with optional static noise and clamping.
// ----------------------------------------------------------------------------
// Usage:
//   req_valid/req_ready carry one pixel request (position, corner ids,
//   corner colors, noise); rsp_valid/rsp_ready return one pixel per request,
//   in order.
//   The pipeline has 4 register stages. Stage 1 clamps the position and
//   forms the corner weights, stage 2 divides each corner channel by
//   (S-1) through a reciprocal multiply, stage 3 takes the weighted sum,
//   stage 4 applies the copy path, noise and clamp.
//   Throughput is one pixel per cycle while rsp_ready stays high; the four
//   stage registers with their valid bits set that figure.
//   Each stage holds its item while the next one is full, so a stalled
//   receiver fills the pipeline and req_ready drops only once all four
//   stages are occupied. Nothing is dropped or repeated.
//   csr_we writes sample_precision (index 0, reset 2) or noise_enable
//   (index 1, reset 0); write only while the core is empty.
//   Synchronous reset empties the pipeline and restores the registers.
// ----------------------------------------------------------------------------
`default_nettype none

module terrain_corner_blend_pixel_core (
   input  wire                              clock,
   input  wire                              reset,
   input  wire                              req_valid,
   output logic                             req_ready,
   input  tcb_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  wire                              rsp_ready,
   output tcb_pkg::rsp_type                 rsp_data,
   input  wire                              csr_we,
   input  wire [tcb_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  wire [tcb_pkg::CSR_DATA_WIDTH-1:0] csr_wdata
);

   localparam int PW = tcb_pkg::PREC_WIDTH;
   localparam int WW = tcb_pkg::WEIGHT_WIDTH;

   // configuration
   logic [PW-1:0] precision_ff, precision_in;
   logic          noise_en_ff, noise_en_in;

   always_comb begin
      precision_in = precision_ff;
      noise_en_in  = noise_en_ff;
      if (csr_we) begin
         unique case (csr_index)
            tcb_pkg::CSR_SAMPLE_PRECISION: precision_in = csr_wdata[PW-1:0];
            tcb_pkg::CSR_NOISE_ENABLE:     noise_en_in  = csr_wdata[0];
            default: ;
         endcase
      end
   end

   // pipeline flow control
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic ld1, ld2, ld3, ld4;
   tcb_pkg::stage_en_type stage_en;

   assign ld4 = !v4_ff || rsp_ready;
   assign ld3 = !v3_ff || ld4;
   assign ld2 = !v2_ff || ld3;
   assign ld1 = !v1_ff || ld2;
   assign req_ready   = ld1;
   assign stage_en.s2 = ld2;
   assign stage_en.s3 = ld3;

   // stage 1: clamp, weights, copy-path decision
   logic [PW-1:0]  p_eff;
   logic [WW-1:0]  div;
   logic [WW-1:0]  x_c, y_c, mx, mn;
   tcb_pkg::weight_type w1_in, w1_ff;
   logic           uni1_in, uni1_ff;
   logic [tcb_pkg::RECIP_WIDTH-1:0] recip1_ff;
   logic [23:0]    col1_ff [4];
   logic signed [7:0] noise1_ff;
   logic           nen1_ff;

   always_comb begin
      p_eff = (precision_ff > PW'(tcb_pkg::MAX_PRECISION)) ?
              PW'(tcb_pkg::MAX_PRECISION) : precision_ff;
      div   = WW'(((WW+1)'(1) << p_eff) - (WW+1)'(1));
      x_c   = (req_data.pos_x > div) ? div : req_data.pos_x;
      y_c   = (req_data.pos_y > div) ? div : req_data.pos_y;
      mx    = (x_c > y_c) ? x_c : y_c;
      mn    = (x_c < y_c) ? x_c : y_c;
      w1_in[0] = div - mx;
      w1_in[1] = (x_c > y_c) ? (x_c - y_c) : '0;
      w1_in[2] = mn;
      w1_in[3] = (y_c > x_c) ? (y_c - x_c) : '0;
      uni1_in  = (p_eff == '0) ||
                 ((req_data.id_top_left == req_data.id_top_right) &&
                  (req_data.id_top_left == req_data.id_bottom_right) &&
                  (req_data.id_top_left == req_data.id_bottom_left));
   end

   // stage 2 / 3 side data
   tcb_pkg::weight_type w2_ff;
   logic              uni2_ff, uni3_ff;
   logic [23:0]       tl2_ff, tl3_ff;
   logic signed [7:0] noise2_ff, noise3_ff;
   logic              nen2_ff, nen3_ff;

   // per-channel blend; red 23:16, green 15:8, blue 7:0
   logic [7:0] blend [3];

   for (genvar c = 0; c < 3; c++) begin : g_chan
      tcb_pkg::corner_chan_type chan;
      always_comb begin
         for (int k = 0; k < 4; k++) begin
            chan[k] = col1_ff[k][(2-c)*8 +: 8];
         end
      end
      tcb_channel u_channel (
         .clock    (clock),
         .stage_en (stage_en),
         .chan     (chan),
         .recip    (recip1_ff),
         .weight   (w2_ff),
         .sum      (blend[c])
      );
   end

   // stage 4: copy path, noise, clamp
   function automatic logic [7:0] add_noise(input logic [7:0] c,
                                            input logic signed [7:0] n);
      logic signed [9:0] v;
      begin
         v = $signed({2'b00, c}) + 10'(n);
         if (v < 0) begin
            return 8'd0;
         end else if (v > 10'sd255) begin
            return 8'd255;
         end
         return v[7:0];
      end
   endfunction

   logic [7:0]       rgb [3];
   tcb_pkg::rsp_type rsp4_in, rsp4_ff;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         rgb[c] = uni3_ff ? tl3_ff[(2-c)*8 +: 8] : blend[c];
         if (nen3_ff) begin
            rgb[c] = add_noise(rgb[c], noise3_ff);
         end
      end
      rsp4_in.red         = rgb[0];
      rsp4_in.green       = rgb[1];
      rsp4_in.blue        = rgb[2];
      rsp4_in.alpha       = tcb_pkg::ALPHA_OPAQUE;
      rsp4_in.was_uniform = uni3_ff;
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         precision_ff <= tcb_pkg::PRECISION_RESET;
         noise_en_ff  <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
      end else begin
         precision_ff <= precision_in;
         noise_en_ff  <= noise_en_in;
         if (ld1) v1_ff <= req_valid;
         if (ld2) v2_ff <= v1_ff;
         if (ld3) v3_ff <= v2_ff;
         if (ld4) v4_ff <= v3_ff;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (ld1) begin
         w1_ff      <= w1_in;
         uni1_ff    <= uni1_in;
         recip1_ff  <= tcb_pkg::recip_of(p_eff);
         col1_ff[0] <= req_data.color_top_left;
         col1_ff[1] <= req_data.color_top_right;
         col1_ff[2] <= req_data.color_bottom_right;
         col1_ff[3] <= req_data.color_bottom_left;
         noise1_ff  <= req_data.noise_value;
         nen1_ff    <= noise_en_ff;
      end
      if (ld2) begin
         w2_ff     <= w1_ff;
         uni2_ff   <= uni1_ff;
         tl2_ff    <= col1_ff[0];
         noise2_ff <= noise1_ff;
         nen2_ff   <= nen1_ff;
      end
      if (ld3) begin
         uni3_ff   <= uni2_ff;
         tl3_ff    <= tl2_ff;
         noise3_ff <= noise2_ff;
         nen3_ff   <= nen2_ff;
      end
      if (ld4) begin
         rsp4_ff <= rsp4_in;
      end
   end

   assign rsp_valid = v4_ff;
   assign rsp_data  = rsp4_ff;

endmodule

`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for terrain_corner_blend_pixel_core: directed corner,
// precision and noise cases, then random pixels under mixed idle patterns
// and a long receiver stall, each checked against an in-bench blend model.
// ----------------------------------------------------------------------------

module tb;

   localparam int PIPE_LATENCY     = 4;
   localparam int STALL_LIMIT      = 2000;
   localparam int RANDOM_PER_PHASE = 270;
   localparam int MAX_SEND_GAP     = 20;

   logic                               clock     = 1'b0;
   logic                               reset     = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_ready;
   tcb_pkg::req_type                   req_data  = '0;
   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   tcb_pkg::rsp_type                   rsp_data;
   logic                               csr_we    = 1'b0;
   logic [tcb_pkg::CSR_IDX_WIDTH-1:0]  csr_index = '0;
   logic [tcb_pkg::CSR_DATA_WIDTH-1:0] csr_wdata = '0;

   // Bench copy of the control registers
   logic [tcb_pkg::PREC_WIDTH-1:0] cur_precision = tcb_pkg::PRECISION_RESET;
   logic                           cur_noise_on  = 1'b0;

   tcb_pkg::rsp_type pending_pixels[$];

   int sender_idle_pct    = 0;
   int receiver_stall_pct = 0;
   int hold_off_left      = 0;
   int mismatches         = 0;
   int pixels_checked     = 0;
   int quiet_cycles       = 0;

   always #5 clock = ~clock;

   terrain_corner_blend_pixel_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Expected pixel: copy path or four-corner triangular blend, then noise
   function automatic tcb_pkg::rsp_type blend_pixel(
         input tcb_pkg::req_type px,
         input logic [tcb_pkg::PREC_WIDTH-1:0] prec_reg,
         input logic noise_on);
      tcb_pkg::rsp_type res;
      int          prec, div, x, y, mx, mn, sum, val, noise, shift;
      int          wt[4];
      logic [23:0] corner[4];
      logic [7:0]  rgb[3];
      logic        uniform;
      prec = (prec_reg > tcb_pkg::MAX_PRECISION) ? tcb_pkg::MAX_PRECISION : int'(prec_reg);
      corner[0] = px.color_top_left;
      corner[1] = px.color_top_right;
      corner[2] = px.color_bottom_right;
      corner[3] = px.color_bottom_left;
      noise = int'($signed(px.noise_value));
      uniform = (prec == 0) ||
                (px.id_top_left == px.id_top_right &&
                 px.id_top_left == px.id_bottom_right &&
                 px.id_top_left == px.id_bottom_left);
      div = (1 << prec) - 1;
      x = (px.pos_x > div) ? div : int'(px.pos_x);
      y = (px.pos_y > div) ? div : int'(px.pos_y);
      mx = (x > y) ? x : y;
      mn = (x < y) ? x : y;
      wt[0] = div - mx;
      wt[1] = (x > y) ? x - y : 0;
      wt[2] = mn;
      wt[3] = (y > x) ? y - x : 0;
      for (int ch = 0; ch < 3; ch++) begin
         shift = 16 - 8 * ch;
         if (uniform) begin
            val = (corner[0] >> shift) & 'hFF;
         end else begin
            sum = 0;
            for (int k = 0; k < 4; k++)
               sum += wt[k] * (((corner[k] >> shift) & 'hFF) / div);
            val = (sum > 255) ? 255 : sum;
         end
         if (noise_on) begin
            val += noise;
            if (val < 0) val = 0;
            if (val > 255) val = 255;
         end
         rgb[ch] = val[7:0];
      end
      res.red         = rgb[0];
      res.green       = rgb[1];
      res.blue        = rgb[2];
      res.alpha       = tcb_pkg::ALPHA_OPAQUE;
      res.was_uniform = uniform;
      return res;
   endfunction

   function automatic tcb_pkg::req_type make_pixel(input int x, input int y,
                                                   input int id_tl, input int id_tr,
                                                   input int id_br, input int id_bl,
                                                   input int c_tl, input int c_tr,
                                                   input int c_br, input int c_bl,
                                                   input int noise);
      tcb_pkg::req_type px;
      px.pos_x              = x[3:0];
      px.pos_y              = y[3:0];
      px.id_top_left        = id_tl[15:0];
      px.id_top_right       = id_tr[15:0];
      px.id_bottom_right    = id_br[15:0];
      px.id_bottom_left     = id_bl[15:0];
      px.color_top_left     = c_tl[23:0];
      px.color_top_right    = c_tr[23:0];
      px.color_bottom_right = c_br[23:0];
      px.color_bottom_left  = c_bl[23:0];
      px.noise_value        = noise[7:0];
      return px;
   endfunction

   // Missing materials (black) and saturated white show up often
   function automatic logic [23:0] random_color();
      int pick;
      pick = $urandom_range(9);
      if (pick == 0) return 24'h000000;
      if (pick == 1) return 24'hFFFFFF;
      return 24'($urandom);
   endfunction

   function automatic logic [15:0] random_id(input logic [15:0] base);
      if ($urandom_range(2) == 0) return 16'($urandom);
      return base;
   endfunction

   function automatic tcb_pkg::req_type random_pixel();
      tcb_pkg::req_type px;
      int          span, pick;
      logic [15:0] base;
      span = 1 << ((cur_precision > tcb_pkg::MAX_PRECISION) ?
                   tcb_pkg::MAX_PRECISION : int'(cur_precision));
      if ($urandom_range(4) == 0) begin
         px.pos_x = 4'($urandom_range(15));
         px.pos_y = 4'($urandom_range(15));
      end else begin
         px.pos_x = 4'($urandom_range(span - 1));
         px.pos_y = 4'($urandom_range(span - 1));
      end
      base = 16'($urandom);
      if ($urandom_range(9) < 3) begin
         px.id_top_left     = base;
         px.id_top_right    = base;
         px.id_bottom_right = base;
         px.id_bottom_left  = base;
      end else begin
         px.id_top_left     = random_id(base);
         px.id_top_right    = random_id(base);
         px.id_bottom_right = random_id(base);
         px.id_bottom_left  = random_id(base);
      end
      px.color_top_left     = random_color();
      px.color_top_right    = random_color();
      px.color_bottom_right = random_color();
      px.color_bottom_left  = random_color();
      pick = $urandom_range(9);
      if (pick == 0)
         px.noise_value = 8'sh80;
      else if (pick == 1)
         px.noise_value = 8'sh7F;
      else
         px.noise_value = 8'($urandom);
      return px;
   endfunction

   // One request transfer, with a random idle gap in front of it
   task automatic send_pixel(input tcb_pkg::req_type px);
      int gap;
      gap = 0;
      while (gap < MAX_SEND_GAP && $urandom_range(99) < sender_idle_pct)
         gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= px;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      pending_pixels.push_back(blend_pixel(px, cur_precision, cur_noise_on));
   endtask

   task automatic drain_pipeline();
      req_valid <= 1'b0;
      while (pending_pixels.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 2) @(posedge clock);
   endtask

   task automatic write_reg(input logic [tcb_pkg::CSR_IDX_WIDTH-1:0] idx,
                            input int value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value[tcb_pkg::CSR_DATA_WIDTH-1:0];
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == tcb_pkg::CSR_SAMPLE_PRECISION)
         cur_precision = value[tcb_pkg::PREC_WIDTH-1:0];
      else
         cur_noise_on = value[0];
   endtask

   task automatic set_config(input int prec, input int noise_on);
      drain_pipeline();
      write_reg(tcb_pkg::CSR_SAMPLE_PRECISION, prec);
      write_reg(tcb_pkg::CSR_NOISE_ENABLE, noise_on);
   endtask

   task automatic test_corner_weights();
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      set_config(2, 0);
      send_pixel(make_pixel(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
      // each corner alone carries the full weight
      send_pixel(make_pixel(0, 0, 1, 2, 3, 4, 'hFFFFFF, 'h123456, 'hABCDEF, 'h0F0F0F, 0));
      send_pixel(make_pixel(3, 0, 1, 2, 3, 4, 'hFFFFFF, 'h123456, 'hABCDEF, 'h0F0F0F, 0));
      send_pixel(make_pixel(3, 3, 1, 2, 3, 4, 'hFFFFFF, 'h123456, 'hABCDEF, 'h0F0F0F, 0));
      send_pixel(make_pixel(0, 3, 1, 2, 3, 4, 'hFFFFFF, 'h123456, 'hABCDEF, 'h0F0F0F, 0));
      // noise value present but disabled
      send_pixel(make_pixel(2, 1, 7, 7, 7, 8, 'hFF0000, 'h00FF00, 'h0000FF, 'h808080, 5));
      // position beyond the sample saturates
      send_pixel(make_pixel(15, 15, 0, 1, 0, 1, 'hFFFFFF, 'hFFFFFF, 'hFFFFFF, 'hFFFFFF, 0));
      send_pixel(make_pixel(15, 0, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFF, 'hFFFFFF, 0, 0, 0, -128));
      send_pixel(make_pixel(1, 2, 'hFFFF, 'hFFFF, 'hFFFF, 0, 'h102030, 'hC0B0A0, 'h7F7F7F,
                            'hFFFFFF, 0));
   endtask

   task automatic test_precision_limits();
      // zero precision always copies, even with mixed ids
      set_config(0, 0);
      send_pixel(make_pixel(15, 15, 1, 2, 3, 4, 'hA5A5A5, 'hFFFFFF, 'h000000, 'h5A5A5A, 0));
      // out-of-range precision is held at the maximum
      set_config(7, 0);
      send_pixel(make_pixel(15, 15, 1, 2, 3, 4, 'h000000, 'hFFFFFF, 'hFFFFFF, 'h000000, 0));
      send_pixel(make_pixel(7, 9, 1, 2, 3, 4, 'hFFFFFF, 'h808080, 'h404040, 'hF0E0D0, 0));
      set_config(1, 0);
      send_pixel(make_pixel(1, 0, 9, 8, 9, 8, 'h0000FF, 'hFF0000, 'h00FF00, 'hFFFFFF, 0));
      send_pixel(make_pixel(15, 15, 9, 8, 9, 8, 'h0000FF, 'hFF0000, 'h00FF00, 'hFFFFFF, 0));
      set_config(4, 0);
      send_pixel(make_pixel(15, 15, 1, 1, 1, 2, 'h123456, 'h654321, 'hFEDCBA, 'hFFFFFF, 0));
   endtask

   task automatic test_noise_clamp();
      set_config(2, 1);
      send_pixel(make_pixel(0, 0, 5, 5, 5, 5, 'hFFFFFF, 0, 0, 0, 127));
      send_pixel(make_pixel(0, 0, 5, 5, 5, 5, 'h000000, 0, 0, 0, -128));
      send_pixel(make_pixel(1, 1, 1, 2, 3, 4, 'h808080, 'h808080, 'h808080, 'h808080, -1));
      send_pixel(make_pixel(2, 3, 1, 2, 3, 4, 'hFFFFFF, 0, 'h7F7F7F, 'h010203, 127));
      send_pixel(make_pixel(3, 3, 1, 2, 3, 4, 'hFFFFFF, 0, 'h7F7F7F, 'h010203, -128));
   endtask

   task automatic test_random_traffic();
      int phase_send_idle[5] = '{0, 53, 0, 18, 0};
      int phase_rcv_stall[5] = '{0, 0, 53, 18, 0};
      int phase_prec[5]      = '{4, 1, 3, 7, 2};
      int phase_noise[5]     = '{1, 0, 1, 1, 0};
      for (int ph = 0; ph < 5; ph++) begin
         set_config(phase_prec[ph], phase_noise[ph]);
         sender_idle_pct    = phase_send_idle[ph];
         receiver_stall_pct = phase_rcv_stall[ph];
         repeat (RANDOM_PER_PHASE) send_pixel(random_pixel());
      end
   endtask

   // Receiver holds off while the sender keeps offering, so the core fills
   task automatic test_backpressure();
      set_config(3, 1);
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_off_left      = 200;
      repeat (40) send_pixel(random_pixel());
   endtask

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (hold_off_left > 0) begin
         rsp_ready <= 1'b0;
         hold_off_left--;
      end else begin
         rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);
      end
   end

   always @(posedge clock) begin : result_check
      tcb_pkg::rsp_type want;
      if (!reset) begin
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
         end else if (rsp_valid && rsp_ready) begin
            if (pending_pixels.size() == 0) begin
               $error("pixel transfer with no request outstanding");
               mismatches++;
            end else begin
               want = pending_pixels.pop_front();
               pixels_checked++;
               check_field("red", want.red, rsp_data.red);
               check_field("green", want.green, rsp_data.green);
               check_field("blue", want.blue, rsp_data.blue);
               check_field("alpha", want.alpha, rsp_data.alpha);
               check_field("was_uniform", want.was_uniform, rsp_data.was_uniform);
            end
         end
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_corner_weights();
      test_precision_limits();
      test_noise_clamp();
      test_random_traffic();
      test_backpressure();
      drain_pipeline();
      repeat (PIPE_LATENCY * 4) @(posedge clock);
      if (pending_pixels.size() != 0) begin
         $error("%0d expected pixels never arrived", pending_pixels.size());
         mismatches++;
      end
      $display("tb: %0d pixels compared, %0d mismatches", pixels_checked, mismatches);
      $display("tb: covered precisions 0 to 4 plus an oversized one, noise on/off,");
      $display("tb: idle mixes on both sides and a long output stall");
      if (mismatches == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule

[terrain_corner_blend_pixel_core.f]
sv/tcb_pkg.sv
sv/tcb_channel.sv
sv/terrain_corner_blend_pixel_core.sv
verif/tb.sv
